/* src/las_pkg.sv */
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, constants and the B3/S23 cell rule for the life step core.
// ----------------------------------------------------------------------------
package las_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 128;

	// wide enough for any row/column index, step count or area register
	localparam int LIM_W = 11;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET = 6'd25;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	localparam logic [3:0] SURVIVE_CNT = 4'd2;
	localparam logic [3:0] BIRTH_CNT   = 4'd3;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_ADVANCE = 2'd1,
		FUNC_READ    = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_ADV,
		ST_RESULT
	} state_t;

	function automatic logic next_cell(input logic alive, input logic [3:0] n);
		logic res;
		if (alive) begin
			res = (n == SURVIVE_CNT) || (n == BIRTH_CNT);
		end else begin
			res = (n == BIRTH_CNT);
		end
		return res;
	endfunction

endpackage

/* src/las_row_eval.sv */
// ----------------------------------------------------------------------------
// las_row_eval
// Next generation of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module las_row_eval #(
	parameter int MAX_COLS = las_pkg::MAX_COLS_DEF
) (
	input  logic [MAX_COLS-1:0] up_row,
	input  logic [MAX_COLS-1:0] mid_row,
	input  logic [MAX_COLS-1:0] dn_row,
	input  logic [MAX_COLS-1:0] col_mask,
	input  logic                row_ok,
	output logic [MAX_COLS-1:0] new_row
);

	localparam int PW = MAX_COLS + 2;

	logic [PW-1:0] up_p;
	logic [PW-1:0] mid_p;
	logic [PW-1:0] dn_p;

	// zero column on both edges: no wrap-around
	assign up_p  = {1'b0, up_row, 1'b0};
	assign mid_p = {1'b0, mid_row, 1'b0};
	assign dn_p  = {1'b0, dn_row, 1'b0};

	always_comb begin
		logic [3:0] cnt;
		cnt = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
				+ 4'(mid_p[c]) + 4'(mid_p[c+2])
				+ 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
			new_row[c] = row_ok & col_mask[c] & las_pkg::next_cell(mid_row[c], cnt);
		end
	end

endmodule

/* src/life_automaton_step_core.sv */
// ----------------------------------------------------------------------------
// life_automaton_step_core
// B3/S23 cellular automaton on a row-wide single-port-write grid memory.
// ----------------------------------------------------------------------------
// Item flow: an in-range read or write passes row read, modify/write back and
// result into the output register; out-of-range and unused items go straight
// to the result. An advance sweeps one grid row per cycle through the memory's
// read port. One item in flight at a time; the next is taken once its result is
// loaded. Reset: area registers load 80 columns by 25 rows, then a clearing pass
// zeroes the grid row by row while s_tready stays low.
module life_automaton_step_core #(
	parameter int MAX_ROWS = las_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = las_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row[4:0], col[11:5], cell_value[12], zero fill
	input  logic [1:0]  s_tuser,   // func[1:0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // read_value[0], out_of_range[1], generation_done[2]

	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int SW = $clog2(MAX_ROWS + 2);
	localparam int LW = las_pkg::LIM_W;

	// configuration
	logic [7:0] cols_q;
	logic [5:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= las_pkg::COLS_RESET;
			rows_q <= las_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == las_pkg::CFG_COLS) begin
				cols_q <= cfg_data;
			end else begin
				rows_q <= cfg_data[5:0];
			end
		end
	end

	// input beat fields
	las_pkg::func_t in_func;
	logic [4:0]     in_row;
	logic [6:0]     in_col;
	logic           in_val;
	logic           in_inside;
	logic           accept;

	assign in_func = las_pkg::func_t'(s_tuser);
	assign in_row  = s_tdata[4:0];
	assign in_col  = s_tdata[11:5];
	assign in_val  = s_tdata[12];
	assign accept  = s_tvalid && s_tready;

	assign in_inside = (LW'(in_row) < LW'(rows_q)) && (LW'(in_row) < LW'(MAX_ROWS))
		&& (LW'(in_col) < LW'(cols_q)) && (LW'(in_col) < LW'(MAX_COLS));

	// control and item registers
	las_pkg::state_t state_q, state_d;
	logic [SW-1:0]   step_q;
	las_pkg::func_t  func_q;
	logic [4:0]      row_q;
	logic [6:0]      col_q;
	logic            val_q;
	logic            res_rd_q, res_oor_q, res_done_q;
	logic            out_valid_q;
	logic [7:0]      out_data_q;

	// grid memory, one row per word
	logic [MAX_COLS-1:0] mem [MAX_ROWS];
	logic [MAX_COLS-1:0] rdata_q;
	logic                rd_en, wr_en;
	logic [RW-1:0]       rd_addr, wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// sweep datapath: up_q/mid_q hold the old rows above and at the row being written
	logic [MAX_COLS-1:0] up_q, mid_q;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] incoming;
	logic [MAX_COLS-1:0] new_row;
	logic [MAX_COLS-1:0] mod_row;
	logic [SW-1:0]       step_m1, step_m2;
	logic                in_row_ok, out_row_ok;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = LW'(c) < LW'(cols_q);
		end
	end

	assign step_m1 = step_q - SW'(1);
	assign step_m2 = step_q - SW'(2);

	assign in_row_ok = (step_q != '0) && (step_m1 < SW'(MAX_ROWS))
		&& (LW'(step_m1) < LW'(rows_q));
	assign incoming   = in_row_ok ? (rdata_q & col_mask) : '0;
	assign out_row_ok = LW'(step_m2) < LW'(rows_q);

	las_row_eval #(
		.MAX_COLS(MAX_COLS)
	) u_row_eval (
		.up_row  (up_q),
		.mid_row (mid_q),
		.dn_row  (incoming),
		.col_mask(col_mask),
		.row_ok  (out_row_ok),
		.new_row (new_row)
	);

	always_comb begin
		mod_row = rdata_q;
		mod_row[CW'(col_q)] = val_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			las_pkg::ST_CLEAR: begin
				if (step_q == SW'(MAX_ROWS - 1)) begin
					state_d = las_pkg::ST_IDLE;
				end
			end
			las_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_func)
						las_pkg::FUNC_ADVANCE: state_d = las_pkg::ST_ADV;
						las_pkg::FUNC_WRITE,
						las_pkg::FUNC_READ: begin
							state_d = in_inside ? las_pkg::ST_CELL : las_pkg::ST_RESULT;
						end
						default: state_d = las_pkg::ST_RESULT;
					endcase
				end
			end
			las_pkg::ST_CELL: state_d = las_pkg::ST_RESULT;
			las_pkg::ST_ADV: begin
				if (step_q == SW'(MAX_ROWS + 1)) begin
					state_d = las_pkg::ST_RESULT;
				end
			end
			las_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					state_d = las_pkg::ST_IDLE;
				end
			end
			default: state_d = las_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	logic load_out;

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		load_out = 1'b0;
		unique case (state_q)
			las_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = RW'(step_q);
			end
			las_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				rd_en    = accept && in_inside;
				rd_addr  = RW'(in_row);
			end
			las_pkg::ST_CELL: begin
				wr_en   = (func_q == las_pkg::FUNC_WRITE);
				wr_addr = RW'(row_q);
				wr_data = mod_row;
			end
			las_pkg::ST_ADV: begin
				rd_en   = step_q < SW'(MAX_ROWS);
				rd_addr = RW'(step_q);
				wr_en   = step_q >= SW'(2);
				wr_addr = RW'(step_m2);
				wr_data = new_row;
			end
			las_pkg::ST_RESULT: begin
				load_out = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= las_pkg::ST_CLEAR;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == las_pkg::ST_CLEAR || state_q == las_pkg::ST_ADV) begin
				step_q <= step_q + SW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item, window and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= in_func;
			row_q      <= in_row;
			col_q      <= in_col;
			val_q      <= in_val;
			up_q       <= '0;
			mid_q      <= '0;
			res_rd_q   <= 1'b0;
			res_oor_q  <= ((in_func == las_pkg::FUNC_WRITE) || (in_func == las_pkg::FUNC_READ))
				&& !in_inside;
			res_done_q <= (in_func == las_pkg::FUNC_ADVANCE);
		end
		if (state_q == las_pkg::ST_CELL) begin
			res_rd_q <= (func_q == las_pkg::FUNC_READ) & rdata_q[CW'(col_q)];
		end
		if (state_q == las_pkg::ST_ADV && step_q != '0) begin
			up_q  <= mid_q;
			mid_q <= incoming;
		end
		if (load_out) begin
			out_data_q <= {5'b0, res_done_q, res_oor_q, res_rd_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* dv/life_automaton_step_core_tb.sv */
// ----------------------------------------------------------------------------
// life_automaton_step_core_tb
// Self-checking bench for the life step core. Cell writes, reads, unused
// function codes and generation steps stream in under several area settings.
// A scoreboard keeps its own copy of the grid and the area registers, predicts
// every result beat and compares it field by field. Random stalls on both
// streams cover the early phases; the last phases run at full rate.
// ----------------------------------------------------------------------------
module life_automaton_step_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_R = las_pkg::MAX_ROWS_DEF;
	localparam int MAX_C = las_pkg::MAX_COLS_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_PHASES = 9;
	localparam int PHASE_ITEMS = 13;

	typedef struct {
		bit read_value;
		bit out_of_range;
		bit generation_done;
	} life_result_t;

	class life_tracker;
		bit           grid [MAX_R][MAX_C];
		bit [7:0]     cols_in_use;
		bit [5:0]     rows_in_use;
		life_result_t pending_results[$];
		int           errors;
		int           n_items, n_adv, n_reads, n_live, n_oor, n_unused;

		function new();
			cols_in_use = las_pkg::COLS_RESET;
			rows_in_use = las_pkg::ROWS_RESET;
			foreach (grid[r, c]) grid[r][c] = 1'b0;
		endfunction

		function int used_rows();
			return (rows_in_use > MAX_R) ? MAX_R : int'(rows_in_use);
		endfunction

		function int used_cols();
			return (cols_in_use > MAX_C) ? MAX_C : int'(cols_in_use);
		endfunction

		// B3/S23 over the area in use; everything outside it dies, no wrap
		function void next_generation();
			bit nxt [MAX_R][MAX_C];
			int nr, nc, n, rr, cc;
			nr = used_rows();
			nc = used_cols();
			for (int r = 0; r < MAX_R; r++) begin
				for (int c = 0; c < MAX_C; c++) begin
					nxt[r][c] = 1'b0;
					if (r < nr && c < nc) begin
						n = 0;
						for (int dr = -1; dr <= 1; dr++) begin
							for (int dc = -1; dc <= 1; dc++) begin
								rr = r + dr;
								cc = c + dc;
								if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 &&
										rr < nr && cc < nc)
									n += grid[rr][cc];
							end
						end
						if (grid[r][c])
							nxt[r][c] = (n == las_pkg::SURVIVE_CNT) ||
								(n == las_pkg::BIRTH_CNT);
						else
							nxt[r][c] = (n == las_pkg::BIRTH_CNT);
					end
				end
			end
			grid = nxt;
		endfunction

		function void note_item(logic [1:0] func, logic [4:0] row, logic [6:0] col,
				logic val);
			life_result_t res;
			bit in_area;
			res = '{1'b0, 1'b0, 1'b0};
			in_area = (row < used_rows()) && (col < used_cols());
			n_items++;
			case (func)
				las_pkg::FUNC_WRITE: begin
					if (in_area) grid[row][col] = val;
					else res.out_of_range = 1'b1;
				end
				las_pkg::FUNC_ADVANCE: begin
					next_generation();
					res.generation_done = 1'b1;
					n_adv++;
				end
				las_pkg::FUNC_READ: begin
					n_reads++;
					if (in_area) res.read_value = grid[row][col];
					else res.out_of_range = 1'b1;
					n_live += res.read_value;
				end
				default: n_unused++;
			endcase
			n_oor += res.out_of_range;
			pending_results.push_back(res);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic [7:0] data);
			life_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat %02h with nothing pending", data));
				return;
			end
			want = pending_results.pop_front();
			if (data[0] !== want.read_value)
				report_mismatch($sformatf("read_value %b, want %b", data[0], want.read_value));
			if (data[1] !== want.out_of_range)
				report_mismatch($sformatf("out_of_range %b, want %b", data[1],
					want.out_of_range));
			if (data[2] !== want.generation_done)
				report_mismatch($sformatf("generation_done %b, want %b", data[2],
					want.generation_done));
			if (data[7:3] !== 5'd0)
				report_mismatch($sformatf("fill bits %b, want zero", data[7:3]));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // row[4:0], col[11:5], cell_value[12], zero fill
	logic [1:0]  s_tuser;   // func[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // read_value[0], out_of_range[1], generation_done[2]
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [7:0]  cfg_data;

	life_tracker tracker = new();
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_stall;
	int cycle_count;

	life_automaton_step_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: check accepted beats, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= (rx_stall == 1);
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_stall <= $urandom_range(1, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("life_automaton_step_core_tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] func, logic [4:0] row, logic [6:0] col,
			logic val);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {3'b000, val, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_item(func, row, col, val);
	endtask

	// every item answers, so the core is idle once nothing is pending
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_area(logic [7:0] cols, logic [5:0] rows);
		cfg_we    <= 1'b1;
		cfg_index <= las_pkg::CFG_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= las_pkg::CFG_ROWS;
		cfg_data  <= {2'b00, rows};
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.cols_in_use = cols;
		tracker.rows_in_use = rows;
	endtask

	// mostly writes and reads inside a small window so live clusters form
	task automatic random_item(int win_r, int win_c, int win_h, int win_w);
		int pick, nr, nc;
		logic [4:0] r;
		logic [6:0] c;
		logic v;
		nr = tracker.used_rows();
		nc = tracker.used_cols();
		pick = $urandom_range(0, 99);
		r = 5'($urandom_range(0, 31));
		c = 7'($urandom_range(0, 127));
		v = 1'($urandom_range(0, 1));
		if (pick < 40) begin
			if (win_h > 0 && win_w > 0) begin
				r = 5'(win_r + $urandom_range(0, win_h - 1));
				c = 7'(win_c + $urandom_range(0, win_w - 1));
			end
			v = ($urandom_range(0, 3) != 0);
			send_item(las_pkg::FUNC_WRITE, r, c, v);
		end else if (pick < 50) begin
			send_item(las_pkg::FUNC_WRITE, r, c, v);
		end else if (pick < 62) begin
			send_item(las_pkg::FUNC_ADVANCE, r, c, v);
		end else if (pick < 92) begin
			if (win_h > 0 && win_w > 0) begin
				if ($urandom_range(0, 1)) begin
					r = 5'(win_r + $urandom_range(0, win_h - 1));
					c = 7'(win_c + $urandom_range(0, win_w - 1));
				end else begin
					r = 5'($urandom_range(0, nr - 1));
					c = 7'($urandom_range(0, nc - 1));
				end
			end
			send_item(las_pkg::FUNC_READ, r, c, v);
		end else if (pick < 97) begin
			send_item(las_pkg::FUNC_READ, r, c, v);
		end else begin
			send_item(FUNC_UNUSED, r, c, v);
		end
	endtask

	initial begin
		int phase_cols [N_PHASES];
		int phase_rows [N_PHASES];
		int nr, nc, win_r, win_c, win_h, win_w;
		phase_cols = '{0, 1, 128, 255, 6, 0, 3, 80, 200};
		phase_rows = '{0, 1, 32, 63, 5, 0, 3, 0, 40};
		phase_cols[5] = $urandom_range(1, 128);
		phase_rows[5] = $urandom_range(1, 32);

		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= las_pkg::FUNC_WRITE;
		m_tready    <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= las_pkg::CFG_COLS;
		cfg_data    <= '0;
		rx_stall    <= 0;
		cycle_count <= 0;
		tx_idle_en  = 1'b1;
		rx_idle_en  = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on the reset area of 80 x 25
		send_item(las_pkg::FUNC_READ, 5'd0, 7'd0, 1'b0);
		send_item(las_pkg::FUNC_WRITE, 5'd0, 7'd0, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd24, 7'd79, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd25, 7'd0, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd0, 7'd80, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd31, 7'd127, 1'b1);
		send_item(las_pkg::FUNC_READ, 5'd0, 7'd0, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd24, 7'd79, 1'b1);
		send_item(las_pkg::FUNC_READ, 5'd31, 7'd127, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd25, 7'd79, 1'b0);
		// blinker; lone corner cells die on the step
		send_item(las_pkg::FUNC_WRITE, 5'd10, 7'd10, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd10, 7'd11, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd10, 7'd12, 1'b1);
		send_item(las_pkg::FUNC_ADVANCE, 5'd31, 7'd127, 1'b1);
		send_item(las_pkg::FUNC_READ, 5'd9, 7'd11, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd10, 7'd11, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd11, 7'd11, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd10, 7'd10, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd0, 7'd0, 1'b0);
		send_item(FUNC_UNUSED, 5'd31, 7'd127, 1'b1);
		send_item(las_pkg::FUNC_WRITE, 5'd10, 7'd11, 1'b0);
		send_item(las_pkg::FUNC_ADVANCE, 5'd0, 7'd0, 1'b0);
		send_item(las_pkg::FUNC_READ, 5'd10, 7'd11, 1'b0);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_area(8'(phase_cols[p]), 6'(phase_rows[p]));
			tx_idle_en = (p < N_PHASES - 2);
			rx_idle_en = (p < N_PHASES - 2);
			nr = tracker.used_rows();
			nc = tracker.used_cols();
			win_h = (nr < 6) ? nr : 6;
			win_w = (nc < 6) ? nc : 6;
			case ($urandom_range(0, 2))
				0: begin
					win_r = 0;
					win_c = 0;
				end
				1: begin
					win_r = nr - win_h;
					win_c = nc - win_w;
				end
				default: begin
					win_r = $urandom_range(0, nr - win_h);
					win_c = $urandom_range(0, nc - win_w);
				end
			endcase
			repeat (PHASE_ITEMS) random_item(win_r, win_c, win_h, win_w);
		end

		drain();
		repeat (MAX_R + 8) @(posedge clk);
		$display("covered %0d items over %0d area settings: %0d generation steps,",
			tracker.n_items, N_PHASES + 1, tracker.n_adv);
		$display("%0d reads (%0d live), %0d out-of-range, %0d unused codes; %0d mismatches",
			tracker.n_reads, tracker.n_live, tracker.n_oor, tracker.n_unused,
			tracker.errors);
		if (tracker.errors == 0) begin
			$display("life_automaton_step_core_tb: PASS");
		end else begin
			$display("life_automaton_step_core_tb: FAIL");
		end
		$finish;
	end

endmodule

/* life_automaton_step_core.f */
src/las_pkg.sv
src/las_row_eval.sv
src/life_automaton_step_core.sv
dv/life_automaton_step_core_tb.sv
